// ----- rtl/core/brs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants of the broker reconnect sequencer: session phase
// codes, command codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package brs_pkg;

   // Session phase
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_CLOSE     = 3'd1,
      PH_CONNECT   = 3'd2,
      PH_SETTLE    = 3'd3,
      PH_DRAIN     = 3'd4,
      PH_HANDSHAKE = 3'd5
   } phase_type;

   // Command issued with each result beat
   typedef enum logic [3:0] {
      CMD_NONE      = 4'd0,
      CMD_SERVICE   = 4'd1,
      CMD_RECOVER   = 4'd2,
      CMD_START     = 4'd3,
      CMD_RESTART   = 4'd4,
      CMD_CONFIGURE = 4'd5,
      CMD_BEGIN     = 4'd6,
      CMD_GIVE_UP   = 4'd7,
      CMD_CONNECT   = 4'd8,
      CMD_DRAIN     = 4'd9,
      CMD_HANDSHAKE = 4'd10
   } command_type;

   // Register indexes on the CSR port
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_RETRY_INTERVAL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CLOSE_WAIT     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_WAIT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ATTEMPTS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FAIL_LIMIT     = 3'd4;

   // Register reset values
   localparam logic [31:0] RETRY_INTERVAL_RST = 32'd5000;
   localparam logic [15:0] CLOSE_WAIT_RST     = 16'd500;
   localparam logic [15:0] SETTLE_WAIT_RST    = 16'd2000;
   localparam logic [2:0]  MAX_ATTEMPTS_RST   = 3'd3;
   localparam logic [3:0]  FAIL_LIMIT_RST     = 4'd5;

   localparam logic [3:0]  FAIL_COUNT_MAX     = 4'd15;

endpackage
`default_nettype wire

// ----- rtl/core/broker_reconnect_sequencer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// broker_reconnect_sequencer_top
// Poll-driven sequencer that keeps a broker session alive over a data bearer.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one beat per poll pass, carrying the time in ms
//    and the link status and outcome flags. Accepted when req_valid is high
//    and req_stall is low.
//  - Response channel (rsp_*): exactly one beat per request beat, in order,
//    carrying the command, attempt number, reconnecting flag and session_done.
//    Taken when rsp_valid is high and rsp_stall is low.
//  - CSR channel (csr_*): register writes by index; csr_ready is always high.
//    Write only while no request is in flight.
// Pipeline and throughput: a request beat is stored in the input register when
//  accepted; the step (a few compares and a state update) then runs from the
//  input register and loads the result register, which drives rsp_valid. One
//  beat per cycle is sustained while rsp_stall stays low; the step through the
//  session state is the loop that bounds it.
// Reset: synchronous, active high. Clears both stages, the session state and
//  loads the register defaults (retry 5000 ms, close wait 500 ms, settle wait
//  2000 ms, 3 attempts, fail limit 5).
// Stall: while rsp_stall holds a result, the step stops and the input register
//  keeps its beat; req_stall rises only once the input register is also full.
// ----------------------------------------------------------------------------
module broker_reconnect_sequencer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [31:0]                     req_now_ms,
   input  wire logic                            req_data_link_ready,
   input  wire logic                            req_session_up,
   input  wire logic                            req_bearer_alive,
   input  wire logic                            req_transport_ok,
   input  wire logic                            req_handshake_ok,
   // response channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [3:0]                      rsp_command,
   output      logic [2:0]                      rsp_attempt_number,
   output      logic                            rsp_reconnecting,
   output      logic                            rsp_session_done,
   // configuration channel
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [brs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                     csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [31:0] retry_interval_ff;
   logic [15:0] close_wait_ff;
   logic [15:0] settle_wait_ff;
   logic [2:0]  max_attempts_ff;
   logic [3:0]  fail_limit_ff;
   logic        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_interval_ff <= brs_pkg::RETRY_INTERVAL_RST;
         close_wait_ff     <= brs_pkg::CLOSE_WAIT_RST;
         settle_wait_ff    <= brs_pkg::SETTLE_WAIT_RST;
         max_attempts_ff   <= brs_pkg::MAX_ATTEMPTS_RST;
         fail_limit_ff     <= brs_pkg::FAIL_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            brs_pkg::REG_RETRY_INTERVAL: retry_interval_ff <= csr_wdata;
            brs_pkg::REG_CLOSE_WAIT:     close_wait_ff     <= csr_wdata[15:0];
            brs_pkg::REG_SETTLE_WAIT:    settle_wait_ff    <= csr_wdata[15:0];
            brs_pkg::REG_MAX_ATTEMPTS:   max_attempts_ff   <= csr_wdata[2:0];
            brs_pkg::REG_FAIL_LIMIT:     fail_limit_ff     <= csr_wdata[3:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [31:0] in_now_ff;
   logic        in_link_ff;
   logic        in_up_ff;
   logic        in_alive_ff;
   logic        in_tr_ok_ff;
   logic        in_hs_ok_ff;
   logic        out_free;
   logic        step_fire;
   logic        req_accept;

   // result slot frees when empty or when its beat leaves this cycle
   assign out_free   = ~rsp_valid | ~rsp_stall;
   assign step_fire  = in_valid_ff & out_free;
   assign req_stall  = in_valid_ff & ~out_free;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_now_ff   <= req_now_ms;
         in_link_ff  <= req_data_link_ready;
         in_up_ff    <= req_session_up;
         in_alive_ff <= req_bearer_alive;
         in_tr_ok_ff <= req_transport_ok;
         in_hs_ok_ff <= req_handshake_ok;
      end
   end

   // ------------------------------------------------------------------
   // Session state
   // ------------------------------------------------------------------
   brs_pkg::phase_type phase_ff, phase_in;
   logic [31:0] phase_start_ff, phase_start_in;
   logic [2:0]  attempt_ff, attempt_in;
   logic [3:0]  fail_ff, fail_in;
   logic        in_session_ff, in_session_in;
   logic [31:0] last_start_ff, last_start_in;

   // wrapping time differences
   logic [31:0] since_phase;
   logic [31:0] since_start;
   logic [3:0]  attempt_next;
   logic        retry_due;
   logic        close_due;
   logic        settle_due;
   logic        attempts_out;
   logic        fail_over;

   assign since_phase  = in_now_ff - phase_start_ff;
   assign since_start  = in_now_ff - last_start_ff;
   assign attempt_next = {1'b0, attempt_ff} + 4'd1;
   assign retry_due    = since_start >= retry_interval_ff;
   assign close_due    = since_phase >= {16'd0, close_wait_ff};
   assign settle_due   = since_phase >= {16'd0, settle_wait_ff};
   assign attempts_out = attempt_next > {1'b0, max_attempts_ff};
   assign fail_over    = fail_ff > fail_limit_ff;

   // Next state of the session
   always_comb begin
      phase_in       = phase_ff;
      phase_start_in = phase_start_ff;
      attempt_in     = attempt_ff;
      fail_in        = fail_ff;
      in_session_in  = in_session_ff;
      last_start_in  = last_start_ff;
      // link down or session up: hold everything
      if (in_link_ff && !in_up_ff) begin
         if (!in_session_ff) begin
            if (retry_due) begin
               last_start_in = in_now_ff;
               if (in_alive_ff) begin
                  in_session_in = 1'b1;
                  phase_in      = brs_pkg::PH_IDLE;
               end
            end
         end else begin
            unique case (phase_ff)
               brs_pkg::PH_IDLE: begin
                  if (fail_over) begin
                     fail_in       = '0;
                     in_session_in = 1'b0;
                  end else begin
                     attempt_in = '0;
                     phase_in   = brs_pkg::PH_CLOSE;
                  end
               end
               brs_pkg::PH_CLOSE: begin
                  if (attempts_out) begin
                     phase_in      = brs_pkg::PH_IDLE;
                     in_session_in = 1'b0;
                  end else begin
                     attempt_in     = attempt_next[2:0];
                     phase_start_in = in_now_ff;
                     phase_in       = brs_pkg::PH_CONNECT;
                  end
               end
               brs_pkg::PH_CONNECT: begin
                  if (close_due) begin
                     phase_start_in = in_now_ff;
                     phase_in       = in_tr_ok_ff ? brs_pkg::PH_SETTLE
                                                  : brs_pkg::PH_CLOSE;
                  end
               end
               brs_pkg::PH_SETTLE: begin
                  if (settle_due) begin
                     phase_in = brs_pkg::PH_DRAIN;
                  end
               end
               brs_pkg::PH_DRAIN: begin
                  phase_in = brs_pkg::PH_HANDSHAKE;
               end
               brs_pkg::PH_HANDSHAKE: begin
                  if (in_hs_ok_ff) begin
                     fail_in       = '0;
                     phase_in      = brs_pkg::PH_IDLE;
                     in_session_in = 1'b0;
                  end else begin
                     if (fail_ff != brs_pkg::FAIL_COUNT_MAX) begin
                        fail_in = fail_ff + 4'd1;
                     end
                     phase_in = brs_pkg::PH_CLOSE;
                  end
               end
               default: begin
                  phase_in      = brs_pkg::PH_IDLE;
                  in_session_in = 1'b0;
               end
            endcase
         end
      end
   end

   // Command and session_done for this step
   brs_pkg::command_type cmd_w;
   logic                 done_w;

   always_comb begin
      cmd_w  = brs_pkg::CMD_NONE;
      done_w = 1'b0;
      if (in_link_ff) begin
         if (in_up_ff) begin
            cmd_w = brs_pkg::CMD_SERVICE;
         end else if (!in_session_ff) begin
            if (retry_due) begin
               cmd_w = in_alive_ff ? brs_pkg::CMD_START : brs_pkg::CMD_RECOVER;
            end
         end else begin
            unique case (phase_ff)
               brs_pkg::PH_IDLE: begin
                  if (fail_over) begin
                     cmd_w  = brs_pkg::CMD_RESTART;
                     done_w = 1'b1;
                  end else begin
                     cmd_w = brs_pkg::CMD_CONFIGURE;
                  end
               end
               brs_pkg::PH_CLOSE: begin
                  if (attempts_out) begin
                     cmd_w  = brs_pkg::CMD_GIVE_UP;
                     done_w = 1'b1;
                  end else begin
                     cmd_w = brs_pkg::CMD_BEGIN;
                  end
               end
               brs_pkg::PH_CONNECT: begin
                  if (close_due) begin
                     cmd_w = brs_pkg::CMD_CONNECT;
                  end
               end
               brs_pkg::PH_SETTLE: cmd_w = brs_pkg::CMD_NONE;
               brs_pkg::PH_DRAIN:  cmd_w = brs_pkg::CMD_DRAIN;
               brs_pkg::PH_HANDSHAKE: begin
                  cmd_w  = brs_pkg::CMD_HANDSHAKE;
                  done_w = in_hs_ok_ff;
               end
               default: done_w = 1'b1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= brs_pkg::PH_IDLE;
         phase_start_ff <= '0;
         attempt_ff     <= '0;
         fail_ff        <= '0;
         in_session_ff  <= 1'b0;
         last_start_ff  <= '0;
      end else if (step_fire) begin
         phase_ff       <= phase_in;
         phase_start_ff <= phase_start_in;
         attempt_ff     <= attempt_in;
         fail_ff        <= fail_in;
         in_session_ff  <= in_session_in;
         last_start_ff  <= last_start_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic [3:0] rsp_command_ff;
   logic [2:0] rsp_attempt_ff;
   logic       rsp_reconnecting_ff;
   logic       rsp_done_ff;

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_command_ff      <= cmd_w;
         rsp_attempt_ff      <= attempt_in;
         rsp_reconnecting_ff <= in_session_in;
         rsp_done_ff         <= done_w;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command        = rsp_command_ff;
   assign rsp_attempt_number = rsp_attempt_ff;
   assign rsp_reconnecting   = rsp_reconnecting_ff;
   assign rsp_session_done   = rsp_done_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_phase_needs_session: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != brs_pkg::PH_IDLE) |-> in_session_ff)
      else $error("session phase active outside a session");

   a_done_clears_session: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> !rsp_reconnecting_ff)
      else $error("session_done reported while still reconnecting");

   a_start_opens_session: assert property (@(posedge clock) disable iff (reset)
      (step_fire && cmd_w == brs_pkg::CMD_START) |=> in_session_ff)
      else $error("start command did not open a session");

   a_link_down_holds: assert property (@(posedge clock) disable iff (reset)
      (step_fire && !in_link_ff) |=>
         (phase_ff == $past(phase_ff) && fail_ff == $past(fail_ff) &&
          in_session_ff == $past(in_session_ff)))
      else $error("state changed on a link-down poll");

   a_stall_blocks_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !step_fire)
      else $error("step ran while the result register was held");

endmodule
`default_nettype wire

// ----- test/broker_reconnect_sequencer_top_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// broker_reconnect_sequencer_top_checker
// Passive checker for the broker reconnect sequencer. It watches the request,
// response and CSR channels, keeps its own copy of the session state and the
// registers, predicts one result per accepted poll and compares every result
// beat with the oldest prediction.
// ----------------------------------------------------------------------------
module broker_reconnect_sequencer_top_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic [31:0]                     req_now_ms,
   input  wire logic                            req_data_link_ready,
   input  wire logic                            req_session_up,
   input  wire logic                            req_bearer_alive,
   input  wire logic                            req_transport_ok,
   input  wire logic                            req_handshake_ok,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic [3:0]                      rsp_command,
   input  wire logic [2:0]                      rsp_attempt_number,
   input  wire logic                            rsp_reconnecting,
   input  wire logic                            rsp_session_done,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [brs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                     csr_wdata,
   output int unsigned                          error_total,
   output int unsigned                          polls_outstanding
);

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      brs_pkg::command_type command;
      logic [2:0]           attempt;
      logic                 reconnecting;
      logic                 done;
   } poll_outcome_type;

   // register copies
   logic [31:0] cfg_retry_ms;
   logic [15:0] cfg_close_ms;
   logic [15:0] cfg_settle_ms;
   logic [2:0]  cfg_max_attempts;
   logic [3:0]  cfg_fail_limit;

   // session state
   brs_pkg::phase_type sess_phase;
   logic [31:0]        step_mark_ms;
   logic [2:0]         attempts;
   logic [3:0]         hs_failures;
   logic               in_reconnect;
   logic [31:0]        start_mark_ms;

   poll_outcome_type expected_polls[$];

   function automatic poll_outcome_type predict_poll(input logic [31:0] now,
                                                     input logic link, up, alive,
                                                     input logic tr_ok, hs_ok);
      poll_outcome_type     res;
      brs_pkg::command_type cmd;
      logic                 done;
      logic [31:0]          since_start;
      logic [31:0]          elapsed;
      logic [3:0]           next_attempt;
      cmd          = brs_pkg::CMD_NONE;
      done         = 1'b0;
      since_start  = now - start_mark_ms;
      elapsed      = now - step_mark_ms;
      next_attempt = {1'b0, attempts} + 4'd1;
      if (link) begin
         if (up) begin
            cmd = brs_pkg::CMD_SERVICE;
         end else if (!in_reconnect) begin
            // a failed bearer probe still counts as a start for the interval
            if (since_start >= cfg_retry_ms) begin
               start_mark_ms = now;
               if (!alive) begin
                  cmd = brs_pkg::CMD_RECOVER;
               end else begin
                  in_reconnect = 1'b1;
                  sess_phase   = brs_pkg::PH_IDLE;
                  cmd          = brs_pkg::CMD_START;
               end
            end
         end else begin
            case (sess_phase)
               brs_pkg::PH_IDLE: begin
                  if (hs_failures > cfg_fail_limit) begin
                     hs_failures = '0;
                     done        = 1'b1;
                     cmd         = brs_pkg::CMD_RESTART;
                  end else begin
                     attempts   = '0;
                     sess_phase = brs_pkg::PH_CLOSE;
                     cmd        = brs_pkg::CMD_CONFIGURE;
                  end
               end
               brs_pkg::PH_CLOSE: begin
                  if (next_attempt > {1'b0, cfg_max_attempts}) begin
                     sess_phase = brs_pkg::PH_IDLE;
                     done       = 1'b1;
                     cmd        = brs_pkg::CMD_GIVE_UP;
                  end else begin
                     attempts     = next_attempt[2:0];
                     step_mark_ms = now;
                     sess_phase   = brs_pkg::PH_CONNECT;
                     cmd          = brs_pkg::CMD_BEGIN;
                  end
               end
               brs_pkg::PH_CONNECT: begin
                  if (elapsed >= {16'd0, cfg_close_ms}) begin
                     step_mark_ms = now;
                     sess_phase   = tr_ok ? brs_pkg::PH_SETTLE : brs_pkg::PH_CLOSE;
                     cmd          = brs_pkg::CMD_CONNECT;
                  end
               end
               brs_pkg::PH_SETTLE: begin
                  if (elapsed >= {16'd0, cfg_settle_ms}) begin
                     sess_phase = brs_pkg::PH_DRAIN;
                  end
               end
               brs_pkg::PH_DRAIN: begin
                  sess_phase = brs_pkg::PH_HANDSHAKE;
                  cmd        = brs_pkg::CMD_DRAIN;
               end
               brs_pkg::PH_HANDSHAKE: begin
                  if (hs_ok) begin
                     hs_failures = '0;
                     sess_phase  = brs_pkg::PH_IDLE;
                     done        = 1'b1;
                  end else begin
                     if (hs_failures != brs_pkg::FAIL_COUNT_MAX) begin
                        hs_failures = hs_failures + 4'd1;
                     end
                     sess_phase = brs_pkg::PH_CLOSE;
                  end
                  cmd = brs_pkg::CMD_HANDSHAKE;
               end
               default: begin
                  sess_phase = brs_pkg::PH_IDLE;
                  done       = 1'b1;
               end
            endcase
            if (done) in_reconnect = 1'b0;
         end
      end
      res.command      = cmd;
      res.attempt      = attempts;
      res.reconnecting = in_reconnect;
      res.done         = done;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      poll_outcome_type want;
      logic             bad;
      if (reset) begin
         cfg_retry_ms      = brs_pkg::RETRY_INTERVAL_RST;
         cfg_close_ms      = brs_pkg::CLOSE_WAIT_RST;
         cfg_settle_ms     = brs_pkg::SETTLE_WAIT_RST;
         cfg_max_attempts  = brs_pkg::MAX_ATTEMPTS_RST;
         cfg_fail_limit    = brs_pkg::FAIL_LIMIT_RST;
         sess_phase        = brs_pkg::PH_IDLE;
         step_mark_ms      = '0;
         attempts          = '0;
         hs_failures       = '0;
         in_reconnect      = 1'b0;
         start_mark_ms     = '0;
         error_total       = 0;
         polls_outstanding = 0;
         expected_polls.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               brs_pkg::REG_RETRY_INTERVAL: cfg_retry_ms     = csr_wdata;
               brs_pkg::REG_CLOSE_WAIT:     cfg_close_ms     = csr_wdata[15:0];
               brs_pkg::REG_SETTLE_WAIT:    cfg_settle_ms    = csr_wdata[15:0];
               brs_pkg::REG_MAX_ATTEMPTS:   cfg_max_attempts = csr_wdata[2:0];
               brs_pkg::REG_FAIL_LIMIT:     cfg_fail_limit   = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_polls.push_back(predict_poll(req_now_ms, req_data_link_ready,
               req_session_up, req_bearer_alive, req_transport_ok, req_handshake_ok));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_polls.size() == 0) begin
               error_total++;
               if (error_total <= REPORT_LIMIT)
                  $display("%0t: unexpected result cmd=%0d att=%0d rc=%0b done=%0b",
                     $realtime, rsp_command, rsp_attempt_number, rsp_reconnecting,
                     rsp_session_done);
            end else begin
               want = expected_polls.pop_front();
               bad  = (rsp_command !== want.command) ||
                      (rsp_attempt_number !== want.attempt) ||
                      (rsp_reconnecting !== want.reconnecting) ||
                      (rsp_session_done !== want.done);
               if (bad) begin
                  error_total++;
                  if (error_total <= REPORT_LIMIT) begin
                     $display("%0t: result mismatch: expected cmd=%s att=%0d rc=%0b done=%0b",
                        $realtime, want.command.name(), want.attempt,
                        want.reconnecting, want.done);
                     $display("%0t:                  got cmd=%0d att=%0d rc=%0b done=%0b",
                        $realtime, rsp_command, rsp_attempt_number, rsp_reconnecting,
                        rsp_session_done);
                  end
               end
            end
         end
         polls_outstanding = expected_polls.size();
      end
   end

endmodule

// ----- test/broker_reconnect_sequencer_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// broker_reconnect_sequencer_top_test
// Regression for the broker reconnect sequencer. Drives poll beats through a
// directed session walk at reset values, then random polls under several
// register settings (small waits, zero and full-scale extremes, a wide random
// one) with random idle bursts on both channels, a long response hold and a
// sender pause. A side checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module broker_reconnect_sequencer_top_test;

   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int unsigned LONG_HOLD_CYCLES = 80;
   localparam int unsigned QUIET_CYCLES     = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_now_ms = '0;
   logic        req_data_link_ready = 1'b0;
   logic        req_session_up = 1'b0;
   logic        req_bearer_alive = 1'b0;
   logic        req_transport_ok = 1'b0;
   logic        req_handshake_ok = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_command;
   logic [2:0]  rsp_attempt_number;
   logic        rsp_reconnecting;
   logic        rsp_session_done;

   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [brs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]                     csr_wdata = '0;

   int unsigned error_total;
   int unsigned polls_outstanding;
   int unsigned cycle_count = 0;

   // stimulus knobs, the first two shared with the stall generator
   bit          idling_on = 1'b1;
   bit          long_hold_req = 1'b0;
   int unsigned hs_ok_pct = 60;

   // shadow of the current register setting, used to aim time steps at the
   // thresholds
   logic [31:0] set_retry;
   logic [15:0] set_close;
   logic [15:0] set_settle;
   logic [31:0] wall_ms = '0;

   always #4 clock = ~clock;

   broker_reconnect_sequencer_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_now_ms          (req_now_ms),
      .req_data_link_ready (req_data_link_ready),
      .req_session_up      (req_session_up),
      .req_bearer_alive    (req_bearer_alive),
      .req_transport_ok    (req_transport_ok),
      .req_handshake_ok    (req_handshake_ok),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_command         (rsp_command),
      .rsp_attempt_number  (rsp_attempt_number),
      .rsp_reconnecting    (rsp_reconnecting),
      .rsp_session_done    (rsp_session_done),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   broker_reconnect_sequencer_top_checker u_poll_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_now_ms          (req_now_ms),
      .req_data_link_ready (req_data_link_ready),
      .req_session_up      (req_session_up),
      .req_bearer_alive    (req_bearer_alive),
      .req_transport_ok    (req_transport_ok),
      .req_handshake_ok    (req_handshake_ok),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_command         (rsp_command),
      .rsp_attempt_number  (rsp_attempt_number),
      .rsp_reconnecting    (rsp_reconnecting),
      .rsp_session_done    (rsp_session_done),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .error_total         (error_total),
      .polls_outstanding   (polls_outstanding)
   );

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("broker_reconnect_sequencer_top regression: fail");
         $finish;
      end
   end

   // Response stall generator. Change rsp_stall only at the falling edge, one
   // assignment per edge. A long hold, once requested, is counted out here and
   // takes priority over the random bursts.
   initial begin : rsp_stall_gen
      int unsigned burst_left;
      int unsigned hold_left;
      burst_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (!idling_on) begin
            rsp_stall <= 1'b0;
         end else if (burst_left != 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one poll beat and hold it until accepted. Enter and leave at a
   // falling edge; leave valid high so back-to-back beats need no toggle.
   task automatic send_poll(input logic [31:0] now, input logic link, up, alive,
                            input logic tr_ok, hs_ok);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_now_ms          <= now;
      req_data_link_ready <= link;
      req_session_up      <= up;
      req_bearer_alive    <= alive;
      req_transport_ok    <= tr_ok;
      req_handshake_ok    <= hs_ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result has come back, then let
   // the pipeline go quiet.
   task automatic drain_polls();
      req_valid <= 1'b0;
      @(negedge clock);
      while (polls_outstanding != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [brs_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Reprogram all registers while the block is idle.
   task automatic apply_settings(input logic [31:0] retry, input logic [15:0] close_w,
                                 input logic [15:0] settle_w, input logic [2:0] max_att,
                                 input logic [3:0] limit);
      drain_polls();
      write_reg(brs_pkg::REG_RETRY_INTERVAL, retry);
      write_reg(brs_pkg::REG_CLOSE_WAIT, {16'd0, close_w});
      write_reg(brs_pkg::REG_SETTLE_WAIT, {16'd0, settle_w});
      write_reg(brs_pkg::REG_MAX_ATTEMPTS, {29'd0, max_att});
      write_reg(brs_pkg::REG_FAIL_LIMIT, {28'd0, limit});
      csr_valid  <= 1'b0;
      set_retry  = retry;
      set_close  = close_w;
      set_settle = settle_w;
   endtask

   task automatic small_settings();
      apply_settings($urandom_range(0, 60), 16'($urandom_range(0, 40)),
                     16'($urandom_range(0, 40)), 3'($urandom_range(1, 7)),
                     4'($urandom_range(0, 15)));
   endtask

   // Mostly well-formed polls: link up, session down, bearer alive, with time
   // steps aimed at the retry, close and settle thresholds so sessions run
   // deep. A few beats are pure noise with a random clock.
   task automatic random_polls(input int unsigned count);
      logic [31:0] delta;
      logic        link;
      logic        up;
      logic        alive;
      repeat (count) begin
         if ($urandom_range(0, 99) < 8) begin
            wall_ms = $urandom();
            send_poll(wall_ms, $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                      $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                      $urandom_range(0, 1) == 1);
         end else begin
            case ($urandom_range(0, 9))
               0:       delta = 32'd0;
               1:       delta = 32'd1;
               2:       delta = {16'd0, set_close} - 32'd1;
               3:       delta = {16'd0, set_close};
               4:       delta = {16'd0, set_settle} - 32'd1;
               5:       delta = {16'd0, set_settle};
               6:       delta = set_retry;
               7:       delta = set_retry - 32'd1;
               8:       delta = $urandom_range(0, 64);
               default: delta = $urandom();
            endcase
            wall_ms = wall_ms + delta;
            link    = $urandom_range(0, 19) != 0;
            up      = $urandom_range(0, 11) == 0;
            alive   = $urandom_range(0, 7) != 0;
            send_poll(wall_ms, link, up, alive, $urandom_range(0, 3) != 0,
                      $urandom_range(0, 99) < hs_ok_pct);
         end
      end
   endtask

   initial begin
      set_retry  = brs_pkg::RETRY_INTERVAL_RST;
      set_close  = brs_pkg::CLOSE_WAIT_RST;
      set_settle = brs_pkg::SETTLE_WAIT_RST;

      // hold reset, release at a falling edge
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed walk at reset register values: link down, service, retry
      // interval not yet over, failed bearer probe, then one full session with
      // a failed transport connect, a failed handshake and the attempts running
      // out, and a start just before the 32-bit time wrap.
      send_poll(32'd0,     1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd1,     1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_poll(32'd4999,  1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd5000,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_poll(32'd10000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd10001, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd10001, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd10001, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_poll(32'd10002, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd10100, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd10502, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
      send_poll(32'd10503, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd11003, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd12000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd13003, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd13004, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd13005, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
      send_poll(32'd13006, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd13506, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);
      send_poll(32'd13507, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd13508, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd0,     1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd1,     1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_poll(32'd501,   1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      wall_ms = 32'd501;

      // small waits, random limits
      small_settings();
      random_polls(90);

      // Saturate the handshake failure count: no waits, most handshakes
      // fail, restart never allowed. Hold the response side for a long
      // stretch while polls keep coming so the input side backs up.
      hs_ok_pct = 5;
      apply_settings(32'd0, 16'd0, 16'd0, 3'd7, 4'd15);
      long_hold_req = 1'b1;
      random_polls(120);

      // zero extremes: every session gives up at once or restarts the modem
      hs_ok_pct = 60;
      apply_settings(32'd0, 16'd0, 16'd0, 3'd0, 4'd0);
      random_polls(40);

      // full-scale extremes, without idling
      idling_on = 1'b0;
      apply_settings(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 3'd7, 4'd15);
      random_polls(40);
      idling_on = 1'b1;

      // wide random setting
      apply_settings($urandom_range(0, 20000), 16'($urandom()), 16'($urandom()),
                     3'($urandom_range(1, 7)), 4'($urandom_range(0, 15)));
      random_polls(60);

      // pause the sender until everything is back, then resume
      small_settings();
      random_polls(45);
      drain_polls();
      random_polls(45);

      // final stretch with no idling on either side
      small_settings();
      idling_on = 1'b0;
      random_polls(70);

      drain_polls();
      if (error_total == 0 && polls_outstanding == 0) begin
         $display("broker_reconnect_sequencer_top regression: pass");
      end else begin
         $display("broker_reconnect_sequencer_top regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/brs_pkg.sv
rtl/core/broker_reconnect_sequencer_top.sv
test/broker_reconnect_sequencer_top_checker.sv
test/broker_reconnect_sequencer_top_test.sv
